// File: sv/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// shared types and constants of the depth pixel back-projection unit
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int unsigned MAX_FRAME_DIM = 4096;
  localparam int unsigned DIM_W         = $clog2(MAX_FRAME_DIM);
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned DIV_STEPS     = 50;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam logic [23:0] Z_SAT         = 24'd16776960;
  localparam logic [17:0] MM_PER_M_Q8   = 18'd256000;

  typedef enum logic [7:0] {
    REG_STRIDE   = 8'd0,
    REG_WIDTH    = 8'd1,
    REG_HEIGHT   = 8'd2,
    REG_FOCAL_X  = 8'd3,
    REG_FOCAL_Y  = 8'd4,
    REG_CENTER_X = 8'd5,
    REG_CENTER_Y = 8'd6,
    REG_MAX_DIST = 8'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FR_RUN,
    FR_LOAD,
    FR_DIV
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ZCV,
    BK_PRJ,
    BK_DST,
    BK_DWT,
    BK_SQ,
    BK_OUT
  } bk_state_e;

  // effective configuration, dimensions and stride already clamped
  typedef struct packed {
    logic [4:0]         stride;
    logic [DIM_W:0]     width;
    logic [DIM_W:0]     height;
    logic [23:0]        focal_x;
    logic [23:0]        focal_y;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [15:0]        max_dist;
  } cfg_t;

  typedef struct packed {
    logic [31:0]      depth_raw;
    logic             depth_is_float;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] grid_col;
    logic [DIM_W-1:0] grid_row;
    logic             last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [23:0]        point_z;
    logic               point_valid;
    logic [11:0]        cloud_column;
    logic [11:0]        cloud_row;
    logic               last_point;
  } result_t;

endpackage

// File: sv/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front
// pixel counting and decimation; resynchronizes grid position after a
// configuration change by a short serial division
// ----------------------------------------------------------------------------
module dpb_front import dpb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  cfg_wr_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  logic [31:0] depth_raw_i,
  input  logic  depth_is_float_i,
  input  logic  frame_start_i,
  input  logic  full_i,
  output logic  push_o,
  output item_t item_o
);

  fr_state_e        st_q, st_d;
  logic             dirty_q;
  logic [DIM_W-1:0] u_q, v_q, gc_q, gr_q;
  logic [4:0]       cph_q, rph_q;
  logic [3:0]       cnt_q;

  logic [DIM_W-1:0] cu, cv, cgc, cgr, uc, vc;
  logic [4:0]       ccph, crph;
  logic             accept, kept, last_c, last_r, end_c, end_r;
  logic [5:0]       tu, tv;
  logic             bu, bv;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      FR_RUN:  if (dirty_q) st_d = FR_LOAD;
      FR_LOAD: st_d = FR_DIV;
      FR_DIV:  if (cnt_q == 4'(DIM_W - 1)) st_d = FR_RUN;
      default: st_d = FR_RUN;
    endcase
  end

  always_comb begin
    ready_o = (st_q == FR_RUN) && !dirty_q && !full_i;
  end

  assign accept = valid_i && ready_o;

  always_comb begin
    cu   = frame_start_i ? '0 : u_q;
    cv   = frame_start_i ? '0 : v_q;
    cgc  = frame_start_i ? '0 : gc_q;
    cgr  = frame_start_i ? '0 : gr_q;
    ccph = frame_start_i ? '0 : cph_q;
    crph = frame_start_i ? '0 : rph_q;
    kept = (ccph == 5'd0) && (crph == 5'd0)
        && (({2'b0, cu} + (DIM_W+2)'(cfg_i.stride)) <= {1'b0, cfg_i.width})
        && (({2'b0, cv} + (DIM_W+2)'(cfg_i.stride)) <= {1'b0, cfg_i.height});
    last_c = ({2'b0, cu} + (DIM_W+2)'({cfg_i.stride, 1'b0})) > {1'b0, cfg_i.width};
    last_r = ({2'b0, cv} + (DIM_W+2)'({cfg_i.stride, 1'b0})) > {1'b0, cfg_i.height};
    end_c  = ({1'b0, cu} + 1'b1) >= cfg_i.width;
    end_r  = ({1'b0, cv} + 1'b1) >= cfg_i.height;
    uc = ({1'b0, u_q} >= cfg_i.width)  ? '0 : u_q;
    vc = ({1'b0, v_q} >= cfg_i.height) ? '0 : v_q;
    tu = {cph_q, gc_q[DIM_W-1]};
    tv = {rph_q, gr_q[DIM_W-1]};
    bu = tu >= {1'b0, cfg_i.stride};
    bv = tv >= {1'b0, cfg_i.stride};
  end

  assign push_o = accept && kept;
  always_comb begin
    item_o.depth_raw      = depth_raw_i;
    item_o.depth_is_float = depth_is_float_i;
    item_o.col            = cu;
    item_o.row            = cv;
    item_o.grid_col       = cgc;
    item_o.grid_row       = cgr;
    item_o.last           = last_c && last_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= FR_RUN;
      dirty_q <= 1'b0;
      u_q     <= '0;
      v_q     <= '0;
      gc_q    <= '0;
      gr_q    <= '0;
      cph_q   <= '0;
      rph_q   <= '0;
      cnt_q   <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == FR_LOAD) dirty_q <= 1'b0;
      if (cfg_wr_i) dirty_q <= 1'b1;
      unique case (st_q)
        FR_RUN: begin
          if (accept) begin
            if (end_c) begin
              u_q   <= '0;
              cph_q <= '0;
              gc_q  <= '0;
              if (end_r) begin
                v_q   <= '0;
                rph_q <= '0;
                gr_q  <= '0;
              end else begin
                v_q <= cv + 1'b1;
                if (crph + 5'd1 == cfg_i.stride) begin
                  rph_q <= '0;
                  gr_q  <= cgr + 1'b1;
                end else begin
                  rph_q <= crph + 5'd1;
                  gr_q  <= cgr;
                end
              end
            end else begin
              u_q   <= cu + 1'b1;
              v_q   <= cv;
              rph_q <= crph;
              gr_q  <= cgr;
              if (ccph + 5'd1 == cfg_i.stride) begin
                cph_q <= '0;
                gc_q  <= cgc + 1'b1;
              end else begin
                cph_q <= ccph + 5'd1;
                gc_q  <= cgc;
              end
            end
          end
        end
        FR_LOAD: begin
          u_q   <= uc;
          v_q   <= vc;
          gc_q  <= uc;
          gr_q  <= vc;
          cph_q <= '0;
          rph_q <= '0;
          cnt_q <= '0;
        end
        FR_DIV: begin
          cph_q <= bu ? 5'(tu - {1'b0, cfg_i.stride}) : tu[4:0];
          rph_q <= bv ? 5'(tv - {1'b0, cfg_i.stride}) : tv[4:0];
          gc_q  <= {gc_q[DIM_W-2:0], bu};
          gr_q  <= {gr_q[DIM_W-2:0], bv};
          cnt_q <= cnt_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/dpb_fifo.sv
// ----------------------------------------------------------------------------
// dpb_fifo
// short queue of kept pixels between front and back
// ----------------------------------------------------------------------------
module dpb_fifo import dpb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  item_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_q, rp_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_PTR_W+1)'(push_i && !full_o)
                     - (FIFO_PTR_W+1)'(pop_i && !empty_o);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

// File: sv/dpb_div.sv
// ----------------------------------------------------------------------------
// dpb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dpb_div import dpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [49:0] quot_o
);

  logic [49:0]          quot_q;
  logic [23:0]          rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [24:0]          t;
  logic                 ge;

  assign t      = {rem_q, quot_q[49]};
  assign ge     = t >= {1'b0, den_i};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[48:0], ge};
      rem_q  <= ge ? 24'(t - {1'b0, den_i}) : t[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule

// File: sv/dpb_back.sv
// ----------------------------------------------------------------------------
// dpb_back
// depth conversion, projection, range check and output register
// ----------------------------------------------------------------------------
module dpb_back import dpb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    empty_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  bk_state_e   st_q, st_d;
  item_t       it_q;
  logic [41:0] p_q;
  logic signed [9:0] sh_q;
  logic        fbad_q, vld_q;
  logic [23:0] z_q;
  logic        negx_q, negy_q;
  logic [48:0] magx_q, magy_q;
  logic signed [31:0] px_q, py_q;
  logic [63:0] acc_q, limsq_q;
  logic [1:0]  sqc_q;
  logic        ovalid_q;
  result_t     out_q;

  logic [7:0]  ex;
  logic [23:0] mant;
  logic signed [9:0] shv;
  logic        fbad;
  logic [23:0] zf, zi;
  logic [47:0] t48;
  logic [9:0]  n;
  logic [63:0] r64;
  logic signed [26:0] dux, duy;
  logic [26:0] adux, aduy;
  logic [48:0] magx, magy;
  logic        div_start, donex, doney;
  logic [49:0] qx, qy;
  logic [31:0] op;
  logic [63:0] prod;
  logic        fv, load;

  function automatic logic signed [31:0] sat_q(input logic [49:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) r = (q >= 50'h80000000) ? 32'sh80000000 : -$signed(q[31:0]);
    else     r = (q > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    return r;
  endfunction

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (!empty_i) st_d = BK_MUL;
      BK_MUL:  st_d = BK_ZCV;
      BK_ZCV:  st_d = BK_PRJ;
      BK_PRJ:  st_d = vld_q ? BK_DST : BK_OUT;
      BK_DST:  st_d = BK_DWT;
      BK_DWT:  if (donex && doney) st_d = (cfg_i.max_dist == '0) ? BK_OUT : BK_SQ;
      BK_SQ:   if (sqc_q == 2'd3) st_d = BK_OUT;
      BK_OUT:  if (load) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (st_q == BK_IDLE) && !empty_i;
    div_start = st_q == BK_DST;
    load      = (st_q == BK_OUT) && (!ovalid_q || out_ready_i);
  end

  always_comb begin
    ex   = it_q.depth_raw[30:23];
    mant = {ex != 8'd0, it_q.depth_raw[22:0]};
    shv  = $signed({2'b0, (ex == 8'd0) ? 8'd1 : ex}) - 10'sd150;
    fbad = (ex == 8'hFF) || it_q.depth_raw[31] || (it_q.depth_raw[30:0] == '0);
    zi   = {it_q.depth_raw[15:0], 8'd0};
    t48  = {6'd0, p_q} << sh_q[2:0];
    n    = 10'(-sh_q);
    r64  = ({22'd0, p_q} + (64'd1 << (n[5:0] - 6'd1))) >> n[5:0];
    if (sh_q >= 10'sd7) begin
      zf = Z_SAT;
    end else if (sh_q >= 10'sd0) begin
      zf = (t48 > {24'd0, Z_SAT}) ? Z_SAT : t48[23:0];
    end else if (n >= 10'd63) begin
      zf = '0;
    end else begin
      zf = (r64 > {40'd0, Z_SAT}) ? Z_SAT : r64[23:0];
    end
    dux  = $signed({7'd0, it_q.col, 8'd0}) - 27'(cfg_i.center_x);
    duy  = $signed({7'd0, it_q.row, 8'd0}) - 27'(cfg_i.center_y);
    adux = dux[26] ? 27'(-dux) : dux;
    aduy = duy[26] ? 27'(-duy) : duy;
    magx = {24'd0, adux[24:0]} * {25'd0, z_q};
    magy = {24'd0, aduy[24:0]} * {25'd0, z_q};
    unique case (sqc_q)
      2'd0:    op = px_q[31] ? 32'(-px_q) : px_q;
      2'd1:    op = py_q[31] ? 32'(-py_q) : py_q;
      2'd2:    op = {8'd0, z_q};
      default: op = {8'd0, cfg_i.max_dist, 8'd0};
    endcase
    prod = {32'd0, op} * {32'd0, op};
    fv   = vld_q && !((cfg_i.max_dist != '0) && (acc_q > limsq_q));
  end

  dpb_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({1'b0, magx_q} + {27'd0, cfg_i.focal_x[23:1]}),
    .den_i   (cfg_i.focal_x),
    .done_o  (donex),
    .quot_o  (qx)
  );

  dpb_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({1'b0, magy_q} + {27'd0, cfg_i.focal_y[23:1]}),
    .den_i   (cfg_i.focal_y),
    .done_o  (doney),
    .quot_o  (qy)
  );

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      BK_IDLE: it_q <= item_i;
      BK_MUL: begin
        p_q    <= {18'd0, mant} * {24'd0, MM_PER_M_Q8};
        sh_q   <= shv;
        fbad_q <= fbad;
      end
      BK_ZCV: begin
        z_q   <= it_q.depth_is_float ? zf : zi;
        vld_q <= (it_q.depth_is_float ? !fbad_q : (zi != '0))
              && (cfg_i.focal_x != '0) && (cfg_i.focal_y != '0);
      end
      BK_PRJ: begin
        magx_q <= magx;
        magy_q <= magy;
        negx_q <= dux[26];
        negy_q <= duy[26];
      end
      BK_DWT: begin
        px_q  <= sat_q(qx, negx_q);
        py_q  <= sat_q(qy, negy_q);
        acc_q <= '0;
        sqc_q <= '0;
      end
      BK_SQ: begin
        if (sqc_q == 2'd3) limsq_q <= prod;
        else acc_q <= acc_q + prod;
        sqc_q <= sqc_q + 2'd1;
      end
      BK_OUT: begin
        if (load) begin
          out_q.point_x      <= fv ? px_q : '0;
          out_q.point_y      <= fv ? py_q : '0;
          out_q.point_z      <= fv ? z_q : '0;
          out_q.point_valid  <= fv;
          out_q.cloud_column <= it_q.grid_col;
          out_q.cloud_row    <= it_q.grid_row;
          out_q.last_point   <= it_q.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule

// File: sv/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// pinhole back-projection of a raster depth stream into a decimated cloud
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while the four-entry queue between front and
// back has room; pixels off the decimated grid give no point. A kept pixel
// with a valid depth holds the back end through the two 50-step serial
// dividers for x and y that run side by side, and through the range check
// when the cutoff is enabled; an invalid point skips both. A stalled output
// holds the back end in its last step. After any configuration write the
// front recomputes its grid position before it takes the next pixel.
module depth_pixel_backprojection_unit import dpb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // depth_raw
  input  logic [1:0]   s_axis_tuser,  // depth_is_float, frame_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // point_x, point_y, point_z, cloud_column, cloud_row
  output logic         m_axis_tuser,  // point_valid
  output logic         m_axis_tlast   // last_point
);

  logic [4:0]         stride_q;
  logic [12:0]        width_q, height_q;
  logic [23:0]        fx_q, fy_q;
  logic signed [23:0] cx_q, cy_q;
  logic [15:0]        maxd_q;
  cfg_t               cfg;
  logic               cfg_wr, push, full, pop, empty;
  item_t              fitem, bitem;
  result_t            res;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= 5'd1;
      width_q  <= 13'd640;
      height_q <= 13'd480;
      fx_q     <= '0;
      fy_q     <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      maxd_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_addr_i)
        REG_STRIDE:   stride_q <= cfg_data_i[4:0];
        REG_WIDTH:    width_q  <= cfg_data_i[12:0];
        REG_HEIGHT:   height_q <= cfg_data_i[12:0];
        REG_FOCAL_X:  fx_q     <= cfg_data_i[23:0];
        REG_FOCAL_Y:  fy_q     <= cfg_data_i[23:0];
        REG_CENTER_X: cx_q     <= $signed(cfg_data_i[23:0]);
        REG_CENTER_Y: cy_q     <= $signed(cfg_data_i[23:0]);
        REG_MAX_DIST: maxd_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.stride   = (stride_q == '0) ? 5'd1 : stride_q;
    cfg.width    = (width_q == '0) ? 13'd1
                 : (width_q > 13'(MAX_FRAME_DIM)) ? 13'(MAX_FRAME_DIM) : width_q;
    cfg.height   = (height_q == '0) ? 13'd1
                 : (height_q > 13'(MAX_FRAME_DIM)) ? 13'(MAX_FRAME_DIM) : height_q;
    cfg.focal_x  = fx_q;
    cfg.focal_y  = fy_q;
    cfg.center_x = cx_q;
    cfg.center_y = cy_q;
    cfg.max_dist = maxd_q;
  end

  dpb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cfg_wr_i         (cfg_wr),
    .valid_i          (s_axis_tvalid),
    .ready_o          (s_axis_tready),
    .depth_raw_i      (s_axis_tdata),
    .depth_is_float_i (s_axis_tuser[0]),
    .frame_start_i    (s_axis_tuser[1]),
    .full_i           (full),
    .push_o           (push),
    .item_o           (fitem)
  );

  dpb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fitem),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (bitem),
    .empty_o (empty)
  );

  dpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .item_i      (bitem),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {res.cloud_row, res.cloud_column, res.point_z,
                         res.point_y, res.point_x};
  assign m_axis_tuser = res.point_valid;
  assign m_axis_tlast = res.last_point;

endmodule
